@@ src/mets_pkg.sv @@
// ----------------------------------------------------------------------------
// mets_pkg
// Shared types, widths and helpers for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mets_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF    = 28;
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int COORD_WIDTH_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Fixed field widths
  localparam int FIX_W      = 32;  // Q4.28 coordinate / z word
  localparam int STEP_W     = 31;  // per-pixel increment
  localparam int ITER_W     = 12;  // iteration limit
  localparam int CNT_W      = 13;  // iteration counter, also divider width
  localparam int COLOR_W    = 8;   // palette index
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Result packing
  localparam int OUT_FIELDS_W = COLOR_W + CNT_W + 1;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Saturation bounds for the 32-bit fixed-point range
  localparam logic signed [63:0] FIX_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] FIX_MIN = 64'shFFFF_FFFF_8000_0000;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN    = 3'd0,
    REG_Y_MIN    = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } cfg_reg_t;

  // View window handed to the front end
  typedef struct packed {
    logic signed [FIX_W-1:0] x_min;
    logic signed [FIX_W-1:0] y_min;
    logic [STEP_W-1:0]       x_step;
    logic [STEP_W-1:0]       y_step;
  } window_t;

  // One queued point c
  typedef struct packed {
    logic signed [FIX_W-1:0] c_re;
    logic signed [FIX_W-1:0] c_im;
  } cpoint_t;

  // Divider request / response
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quo;
  } div_rsp_t;

  // Clamp a wide signed value into the 32-bit fixed-point range
  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [63:0] v);
    logic signed [FIX_W-1:0] res;
    if (v > FIX_MAX) begin
      res = FIX_MAX[FIX_W-1:0];
    end else if (v < FIX_MIN) begin
      res = FIX_MIN[FIX_W-1:0];
    end else begin
      res = v[FIX_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/mets_front.sv @@
// ----------------------------------------------------------------------------
// mets_front
// Maps a pixel coordinate to the complex point c and pushes it to the queue.
// ----------------------------------------------------------------------------
module mets_front #(
  parameter int COORD_WIDTH = mets_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_WIDTH-1:0] pixel_x,
  input  logic [COORD_WIDTH-1:0] pixel_y,
  input  mets_pkg::window_t     win,
  output logic                  q_valid,
  input  logic                  q_ready,
  output mets_pkg::cpoint_t     q_data
);

  localparam int PX_W   = COORD_WIDTH + 1;
  localparam int PROD_W = PX_W + mets_pkg::STEP_W;
  localparam int SUM_W  = PROD_W + 2;

  logic              s1_valid_r;
  logic [PROD_W-1:0] prod_re_r;
  logic [PROD_W-1:0] prod_im_r;
  logic [PX_W-1:0]   px_inc;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;

  // column index carries the one-step offset
  assign px_inc   = {1'b0, pixel_x} + PX_W'(1);
  assign in_ready = !s1_valid_r || q_ready;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_re_r <= PROD_W'(px_inc) * PROD_W'(win.x_step);
      prod_im_r <= PROD_W'(pixel_y) * PROD_W'(win.y_step);
    end
  end

  // stage 2: offset add and clamp, straight into the queue
  assign sum_re = SUM_W'($signed(win.x_min)) + $signed({2'b00, prod_re_r});
  assign sum_im = SUM_W'($signed(win.y_min)) + $signed({2'b00, prod_im_r});

  assign q_valid     = s1_valid_r;
  assign q_data.c_re = mets_pkg::sat_fix(64'(sum_re));
  assign q_data.c_im = mets_pkg::sat_fix(64'(sum_im));

endmodule

@@ src/mets_fifo.sv @@
// ----------------------------------------------------------------------------
// mets_fifo
// Small register queue of points between the front end and the iteration core.
// ----------------------------------------------------------------------------
module mets_fifo #(
  parameter int DEPTH = mets_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  mets_pkg::cpoint_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output mets_pkg::cpoint_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  mets_pkg::cpoint_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [LVL_W-1:0]  level_r;
  logic              push;
  logic              pop;

  assign wr_ready = level_r != LVL_W'(DEPTH);
  assign rd_valid = level_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/mets_div.sv @@
// ----------------------------------------------------------------------------
// mets_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mets_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mets_pkg::div_req_t req,
  output mets_pkg::div_rsp_t rsp
);

  localparam int W      = mets_pkg::CNT_W;
  localparam int STEP_W = $clog2(W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [W-1:0]      quo_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      dsr_r;
  logic [W:0]        shifted;
  logic [W+1:0]      trial;

  // shift in next dividend bit and try the subtract
  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(W - 1);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        if (!trial[W+1]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ src/mets_core.sv @@
// ----------------------------------------------------------------------------
// mets_core
// Escape-time iteration engine, palette mapping and result register.
// ----------------------------------------------------------------------------
module mets_core #(
  parameter int FRAC_BITS    = mets_pkg::FRAC_BITS_DEF,
  parameter int PALETTE_SIZE = mets_pkg::PALETTE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  mets_pkg::cpoint_t             q_data,
  input  logic [mets_pkg::ITER_W-1:0]   max_iter,
  output mets_pkg::div_req_t            div_req,
  input  mets_pkg::div_rsp_t            div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mets_pkg::COLOR_W-1:0]  out_color,
  output logic [mets_pkg::CNT_W-1:0]    out_count,
  output logic                          out_inside
);

  localparam int FIX_W   = mets_pkg::FIX_W;
  localparam int CNT_W   = mets_pkg::CNT_W;
  localparam int COLOR_W = mets_pkg::COLOR_W;
  // width of the shifted squares and their sums
  localparam int WW = ((66 - FRAC_BITS) > (FRAC_BITS + 4)) ? (66 - FRAC_BITS)
                                                           : (FRAC_BITS + 4);
  localparam logic signed [WW-1:0] FOUR =
    {{(WW - FRAC_BITS - 3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};
  localparam int PAL_MAX = PALETTE_SIZE - 1;
  // reciprocal of PAL_MAX for the remainder on long limits
  localparam int RK   = CNT_W + COLOR_W;
  localparam int RM_W = RK + 1;
  localparam int MP_W = CNT_W + RM_W;
  localparam logic [RM_W-1:0] RECIP = RM_W'((64'd1 << RK) / 64'(PAL_MAX));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_MUL,
    ST_FIN,
    ST_DIV,
    ST_MOD,
    ST_RES
  } state_t;

  state_t                   state_r;
  logic signed [FIX_W-1:0]  c_re_r;
  logic signed [FIX_W-1:0]  c_im_r;
  logic signed [FIX_W-1:0]  zr_r;
  logic signed [FIX_W-1:0]  zi_r;
  logic signed [WW-1:0]     zr2_r;
  logic signed [WW-1:0]     zi2_r;
  logic signed [WW-1:0]     zrzi_r;
  logic [CNT_W-1:0]         count_r;
  logic                     inside_r;
  logic [CNT_W-1:0]         mod_q_r;
  logic [COLOR_W-1:0]       color_r;
  logic                     out_valid_r;
  logic [COLOR_W-1:0]       out_color_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_inside_r;

  logic signed [WW-1:0]     sq_sum;
  logic                     escaped;
  logic                     at_limit;
  logic signed [FIX_W-1:0]  zr_new;
  logic signed [FIX_W-1:0]  zi_new;
  logic signed [63:0]       p_rr;
  logic signed [63:0]       p_ii;
  logic signed [63:0]       p_ri;
  logic [CNT_W-1:0]         limit;
  logic                     inside_now;
  logic                     small_limit;
  logic [2*CNT_W-1:0]       prod;
  logic [COLOR_W-1:0]       scaled_color;
  logic [MP_W-1:0]          mod_prod;
  logic [CNT_W-1:0]         mod_rem;
  logic [CNT_W-1:0]         mod_fix;

  // escape test and limit check
  assign limit    = {1'b0, max_iter};
  assign sq_sum   = zr2_r + zi2_r;
  assign escaped  = sq_sum >= FOUR;
  assign at_limit = count_r >= limit;

  // z update from the registered squares and cross term
  assign zr_new = mets_pkg::sat_fix(64'(zr2_r - zi2_r + WW'(c_re_r)));
  assign zi_new = mets_pkg::sat_fix(64'(zrzi_r + WW'(c_im_r)));

  // products of the current z
  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;

  // palette mapping helpers
  assign inside_now  = count_r >= limit;
  assign small_limit = limit < CNT_W'(PALETTE_SIZE);
  assign prod        = (2*CNT_W)'(count_r) * (2*CNT_W)'(div_rsp.quo);
  assign scaled_color = (prod == (2*CNT_W)'(PAL_MAX)) ? '0 : prod[COLOR_W-1:0];

  // count mod PAL_MAX: quotient estimate low by at most one, then one fix-up
  assign mod_prod = MP_W'(count_r) * MP_W'(RECIP);
  assign mod_rem  = count_r - mod_q_r * CNT_W'(PAL_MAX);
  assign mod_fix  = (mod_rem >= CNT_W'(PAL_MAX)) ? mod_rem - CNT_W'(PAL_MAX) : mod_rem;

  // divider launch: palette scale factor for short limits
  always_comb begin
    div_req.start    = (state_r == ST_FIN) && !inside_now && small_limit;
    div_req.dividend = CNT_W'(PALETTE_SIZE);
    div_req.divisor  = limit;
  end

  assign q_ready = state_r == ST_IDLE;

  // sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; the result state reloads the register itself
      if (out_valid_r && out_ready && state_r != ST_RES) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            c_re_r  <= q_data.c_re;
            c_im_r  <= q_data.c_im;
            zr_r    <= '0;
            zi_r    <= '0;
            zr2_r   <= '0;
            zi2_r   <= '0;
            zrzi_r  <= '0;
            count_r <= '0;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (escaped) begin
            state_r <= ST_FIN;
          end else if (at_limit) begin
            count_r <= count_r + 1'b1;
            state_r <= ST_FIN;
          end else begin
            count_r <= count_r + 1'b1;
            zr_r    <= zr_new;
            zi_r    <= zi_new;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          zr2_r   <= WW'(p_rr >>> FRAC_BITS);
          zi2_r   <= WW'(p_ii >>> FRAC_BITS);
          zrzi_r  <= WW'(p_ri >>> (FRAC_BITS - 1));
          state_r <= ST_CHK;
        end
        ST_FIN: begin
          inside_r <= inside_now;
          mod_q_r  <= mod_prod[RK +: CNT_W];
          if (inside_now) begin
            color_r <= COLOR_W'(PAL_MAX);
            state_r <= ST_RES;
          end else if (small_limit) begin
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_MOD;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            color_r <= scaled_color;
            state_r <= ST_RES;
          end
        end
        ST_MOD: begin
          color_r <= mod_fix[COLOR_W-1:0];
          state_r <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_color_r  <= color_r;
            out_count_r  <= count_r;
            out_inside_r <= inside_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_color  = out_color_r;
  assign out_count  = out_count_r;
  assign out_inside = out_inside_r;

endmodule

@@ src/mandelbrot_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator: pixel coordinate in, palette index and count out.
// ----------------------------------------------------------------------------
// Each pixel (pixel_x, pixel_y) maps to c = x_min + (pixel_x+1)*x_step +
// i*(y_min + pixel_y*y_step) in signed Q4.28, and z = z*z + c is iterated from
// zero until |z|^2 reaches 4 or the limit is passed. The front end takes a
// pixel per cycle while the queue accepts, registers its products and feeds a
// short point queue, so a new pixel can be taken while the core works. Each
// core update is an add/clamp/compare state followed by a multiply state. A
// pixel that escapes under a limit of PALETTE_SIZE or more takes its palette
// index from a remainder step, and one that escapes under a smaller limit
// waits for the 13-step serial divider that forms the palette scale. A
// finished result waits in an output register while the next pixel starts.
// Configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS    = mets_pkg::FRAC_BITS_DEF,
  parameter int PALETTE_SIZE = mets_pkg::PALETTE_SIZE_DEF,
  parameter int COORD_WIDTH  = mets_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = mets_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_W        = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // pixel_x, pixel_y, zero pad
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mets_pkg::OUT_W-1:0]        out_tdata,  // color_index, iteration_count,
                                                        // inside_res, zero pad
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mets_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mets_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FIX_W   = mets_pkg::FIX_W;
  localparam int STEP_W  = mets_pkg::STEP_W;
  localparam int ITER_W  = mets_pkg::ITER_W;
  localparam int CNT_W   = mets_pkg::CNT_W;
  localparam int COLOR_W = mets_pkg::COLOR_W;

  logic signed [FIX_W-1:0] x_min_r;
  logic signed [FIX_W-1:0] y_min_r;
  logic [STEP_W-1:0]       x_step_r;
  logic [STEP_W-1:0]       y_step_r;
  logic [ITER_W-1:0]       max_iter_r;

  mets_pkg::window_t  win;
  mets_pkg::cpoint_t  fq_data;
  mets_pkg::cpoint_t  qc_data;
  mets_pkg::div_req_t div_req;
  mets_pkg::div_rsp_t div_rsp;
  logic               fq_valid;
  logic               fq_ready;
  logic               qc_valid;
  logic               qc_ready;
  logic [COLOR_W-1:0] res_color;
  logic [CNT_W-1:0]   res_count;
  logic               res_inside;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= 32'shE000_0000;
      y_min_r    <= 32'shE800_0000;
      x_step_r   <= 31'd2013265;
      y_step_r   <= 31'd2013265;
      max_iter_r <= 12'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mets_pkg::REG_X_MIN:    x_min_r    <= cfg_data;
        mets_pkg::REG_Y_MIN:    y_min_r    <= cfg_data;
        mets_pkg::REG_X_STEP:   x_step_r   <= cfg_data[STEP_W-1:0];
        mets_pkg::REG_Y_STEP:   y_step_r   <= cfg_data[STEP_W-1:0];
        mets_pkg::REG_MAX_ITER: max_iter_r <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign win.x_min  = x_min_r;
  assign win.y_min  = y_min_r;
  assign win.x_step = x_step_r;
  assign win.y_step = y_step_r;

  // front end: pixel to point
  mets_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .pixel_x  (in_tdata[COORD_WIDTH-1:0]),
    .pixel_y  (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .win      (win),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // point queue
  mets_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qc_valid),
    .rd_ready (qc_ready),
    .rd_data  (qc_data)
  );

  // iteration core
  mets_core #(
    .FRAC_BITS   (FRAC_BITS),
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qc_valid),
    .q_ready    (qc_ready),
    .q_data     (qc_data),
    .max_iter   (max_iter_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_color  (res_color),
    .out_count  (res_count),
    .out_inside (res_inside)
  );

  // palette divider
  mets_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tdata = {{(mets_pkg::OUT_W - mets_pkg::OUT_FIELDS_W){1'b0}},
                      res_inside, res_count, res_color};

endmodule

@@ src/mets_chk.sv @@
// ----------------------------------------------------------------------------
// mets_chk
// Port-level checks for the escape-time evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module mets_chk #(
  parameter int PALETTE_SIZE = mets_pkg::PALETTE_SIZE_DEF,
  parameter int COORD_WIDTH  = mets_pkg::COORD_WIDTH_DEF,
  localparam int IN_W        = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [IN_W-1:0]                 in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mets_pkg::OUT_W-1:0]      out_tdata
);

  localparam int COLOR_W = mets_pkg::COLOR_W;
  localparam int CNT_W   = mets_pkg::CNT_W;

  logic [COLOR_W-1:0] color;
  logic [CNT_W-1:0]   count;
  logic               bounded;

  assign color   = out_tdata[COLOR_W-1:0];
  assign count   = out_tdata[COLOR_W+CNT_W-1:COLOR_W];
  assign bounded = out_tdata[COLOR_W+CNT_W];

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // offered pixel stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("stalled pixel changed");

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // bounded points carry the top palette entry, escaped points never do
  a_inside_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (bounded == (color == COLOR_W'(PALETTE_SIZE - 1))))
    else $error("palette index disagrees with inside flag");

  // at least one pass through the loop for every pixel
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count != '0)
    else $error("zero iteration count");

endmodule

bind mandelbrot_escape_time_pixel mets_chk #(
  .PALETTE_SIZE(PALETTE_SIZE),
  .COORD_WIDTH (COORD_WIDTH)
) u_mets_chk (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
// Pixels are streamed in from a queue, and results are collected at the output
// with random gaps and stalls on both sides. Each accepted pixel is run
// through a local fixed-point escape-time model under the current view window,
// and the expected color, count and inside flag are queued in order. A short
// directed section covers the field extremes, coordinate saturation, the
// smallest and largest iteration limits, a zero limit and an escape on the
// last allowed update. Random windows and limits follow. The bench drains
// completely before every register write.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = mets_pkg::FRAC_BITS_DEF;
  localparam int PALETTE  = mets_pkg::PALETTE_SIZE_DEF;
  localparam int PIX_W    = 24;
  localparam int STALL_MAX = 40000;  // cycles without any transaction

  // Pixel transaction, packed to match in_tdata (pixel_x in the low bits)
  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
  } pixel_t;

  // Result transaction, packed to match out_tdata[21:0]
  typedef struct packed {
    logic        bounded;
    logic [12:0] count;
    logic [7:0]  color;
  } escape_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [PIX_W-1:0]                in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mets_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  mets_pkg::cfg_reg_t              cfg_index = mets_pkg::REG_X_MIN;
  logic [mets_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the view window and iteration limit
  longint      win_x_min = -64'sd536870912;
  longint      win_y_min = -64'sd402653184;
  longint      win_x_step = 64'sd2013265;
  longint      win_y_step = 64'sd2013265;
  int unsigned iter_limit = 32;

  pixel_t      pending_pixels[$];
  escape_t     expected_escapes[$];
  int          mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_calm = 0;
  int unsigned quiet_cycles = 0;

  mandelbrot_escape_time_pixel u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // pixel_x, pixel_y
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // color_index, iteration_count, inside_res, pad
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit fixed-point range
  function automatic longint clamp_fix(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time iteration for one pixel under the current window
  function automatic escape_t escape_time(input pixel_t p);
    longint      c_re, c_im, zr, zi, zr2, zi2, bound;
    int unsigned n, scale, color;
    bit          done;
    escape_t     r;
    bound = longint'(4) << FRAC;
    c_re  = clamp_fix(win_x_min + (longint'(p.x) + 1) * win_x_step);
    c_im  = clamp_fix(win_y_min + longint'(p.y) * win_y_step);
    zr = 0; zi = 0; zr2 = 0; zi2 = 0;
    n = 0;
    done = 1'b0;
    while (!done && (zr2 + zi2 < bound)) begin
      n++;
      if (n > iter_limit) begin
        done = 1'b1;
      end else begin
        // imaginary part first: it needs the old real part
        zi  = clamp_fix(((zr * zi) >>> (FRAC - 1)) + c_im);
        zr  = clamp_fix(zr2 - zi2 + c_re);
        zr2 = (zr * zr) >>> FRAC;
        zi2 = (zi * zi) >>> FRAC;
      end
    end
    r.count   = n[12:0];
    r.bounded = (n >= iter_limit);
    if (r.bounded) begin
      color = PALETTE - 1;
    end else begin
      scale = 1;
      if (iter_limit > 0 && iter_limit < PALETTE) scale = PALETTE / iter_limit;
      color = (n * scale) % (PALETTE - 1);
    end
    r.color = color[7:0];
    return r;
  endfunction

  // Gap length: mostly none or short, a few long, and calm stretches
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  // Wait until every pixel is sent and every result has come back
  task automatic settle();
    while (pending_pixels.size() != 0 || in_tvalid || expected_escapes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write transaction; the local copy follows on acceptance
  task automatic write_reg(input mets_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mets_pkg::REG_X_MIN:    win_x_min  = longint'(signed'(val));
      mets_pkg::REG_Y_MIN:    win_y_min  = longint'(signed'(val));
      mets_pkg::REG_X_STEP:   win_x_step = longint'(val[30:0]);
      mets_pkg::REG_Y_STEP:   win_y_step = longint'(val[30:0]);
      mets_pkg::REG_MAX_ITER: iter_limit = val[11:0];
      default: ;
    endcase
  endtask

  // Drain, then load a full window and limit
  task automatic set_window(input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] xs, input logic [31:0] ys,
                            input logic [31:0] lim);
    settle();
    write_reg(mets_pkg::REG_X_MIN, x0);
    write_reg(mets_pkg::REG_Y_MIN, y0);
    write_reg(mets_pkg::REG_X_STEP, xs);
    write_reg(mets_pkg::REG_Y_STEP, ys);
    write_reg(mets_pkg::REG_MAX_ITER, lim);
  endtask

  task automatic add_pixel(input int unsigned px, input int unsigned py);
    pixel_t p;
    p.x = px[11:0];
    p.y = py[11:0];
    pending_pixels.push_back(p);
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_escapes.push_back(escape_time(pixel_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_tdata  <= pending_pixels.pop_front();
          in_tvalid <= 1'b1;
          send_gap  <= idle_len(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin : result_check
    escape_t     want;
    escape_t     got;
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = escape_t'(out_tdata[21:0]);
        if (expected_escapes.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_escapes.pop_front();
          if (got.color !== want.color) begin
            $error("color_index: expected %0d, got %0d", want.color, got.color);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
          if (got.bounded !== want.bounded) begin
            $error("inside_res: expected %0d, got %0d", want.bounded, got.bounded);
            mismatches++;
          end
        end
      end
      // backpressure: stall after some transactions and at random moments
      if (recv_stall != 0) begin
        out_tready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if ((out_tvalid && out_tready) || $urandom_range(0, 15) == 0) begin
        stall = idle_len(recv_calm);
        out_tready <= (stall == 0);
        recv_stall <= (stall == 0) ? 0 : stall - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
          $display("FAIL mandelbrot_escape_time_pixel");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    pixel_t      p;
    escape_t     pr;
    bit          found;
    int          x0, y0;
    logic [31:0] xs, ys;
    int unsigned lim, n_items, placed, r;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset window: corners and alternating bit patterns
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(12'h555, 12'hAAA);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(100, 200);

    // most negative corner, zero steps, single-update limit
    set_window(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1);
    add_pixel(0, 0);
    add_pixel(4095, 4095);

    // coordinates saturating high, full-range steps
    set_window(32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 255);
    add_pixel(4095, 4095);
    add_pixel(0, 0);
    add_pixel(0, 1);

    // zero limit: every pixel counts as inside
    set_window(-(1 << 27), 0, 1, 1, 0);
    add_pixel(0, 0);
    add_pixel(4095, 4095);

    // largest limit on bounded points
    set_window(-(1 << 27), 0, 1, 1, 4095);
    add_pixel(0, 0);
    add_pixel(4095, 4095);

    // limit equal to the palette size
    set_window(-536870912, -402653184, 2013265, 2013265, 256);
    add_pixel(100, 200);
    add_pixel(10, 10);
    add_pixel(300, 150);

    // escape on the last allowed update
    set_window(-536870912, -402653184, 2013265, 2013265, 16);
    found = 1'b0;
    for (int k = 0; k < 4000 && !found; k++) begin
      p.x = $urandom_range(0, 300);
      p.y = $urandom_range(0, 400);
      pr = escape_time(p);
      if (pr.count == iter_limit) begin
        found = 1'b1;
        pending_pixels.push_back(p);
      end
    end
    add_pixel(150, 200);

    // random windows and limits
    placed = 0;
    while (placed < 1750) begin
      r = $urandom_range(0, 99);
      if (r < 70)      lim = $urandom_range(1, 64);
      else if (r < 90) lim = $urandom_range(65, 300);
      else if (r < 97) lim = $urandom_range(301, 1000);
      else             lim = $urandom_range(1001, 4095);
      if ($urandom_range(0, 9) < 7) begin
        // window over the interesting part of the plane, sometimes deep zoom
        x0 = int'($urandom_range(0, 805306368)) - 671088640;
        y0 = int'($urandom_range(0, 805306368)) - 402653184;
        if ($urandom_range(0, 3) == 0) begin
          xs = $urandom_range(0, 64);
          ys = $urandom_range(0, 64);
        end else begin
          xs = $urandom_range(1, 196608);
          ys = $urandom_range(1, 196608);
        end
      end else begin
        x0 = $urandom;
        y0 = $urandom;
        xs = $urandom;
        ys = $urandom;
      end
      set_window(x0, y0, xs, ys, lim);
      if (lim > 1000)     n_items = $urandom_range(2, 5);
      else if (lim > 300) n_items = $urandom_range(5, 20);
      else                n_items = $urandom_range(30, 120);
      repeat (n_items) add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      placed += n_items;
    end

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS mandelbrot_escape_time_pixel");
    end else begin
      $display("FAIL mandelbrot_escape_time_pixel");
    end
    $finish;
  end

endmodule
